### rtl/can_signal_decoder_with_timeouts_top_macros.svh
// ----------------------------------------------------------------------------
// CAN signal decoder assertion macros
// Shared concurrent assertion forms for the decoder top level.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_DECODER_WITH_TIMEOUTS_TOP_MACROS_SVH
`define CAN_SIGNAL_DECODER_WITH_TIMEOUTS_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define CSD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csd: same-cycle check failed");

// next-cycle implication, held off during reset
`define CSD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csd: next-cycle check failed");

`endif

### rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// CAN signal decoder package
// Message IDs, constants and the structs passed between decoder modules.
// ----------------------------------------------------------------------------
package csd_pkg;

	localparam int MSG_N = 6;

	// slot of each message in the age bank and hit vector
	localparam int MSG_ENG   = 0;
	localparam int MSG_MODE  = 1;
	localparam int MSG_BODY  = 2;
	localparam int MSG_TCS   = 3;
	localparam int MSG_SPEED = 4;
	localparam int MSG_ABS   = 5;

	localparam logic [10:0] ID_ENG   = 11'h110;
	localparam logic [10:0] ID_MODE  = 11'h111;
	localparam logic [10:0] ID_BODY  = 11'h112;
	localparam logic [10:0] ID_TCS   = 11'h120;
	localparam logic [10:0] ID_SPEED = 11'h122;
	localparam logic [10:0] ID_ABS   = 11'h12B;

	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef enum logic [1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_LINK    = 2'd1,
		CFG_FLOOR   = 2'd2
	} cfg_idx_t;

	localparam logic [15:0] TIMEOUT_RST = 16'd1000;
	localparam logic [15:0] LINK_RST    = 16'd3000;
	localparam logic [13:0] FLOOR_RST   = 14'd1700;

	localparam logic [15:0] RAW_NONE  = 16'hFFFF;
	localparam logic [7:0]  BATT_NONE = 8'hFF;
	localparam logic [6:0]  POWER_MAX = 7'd100;
	localparam logic [7:0]  SPEED_MAX = 8'd199;

	// floor(x/100) = (x * ceil(2^24/100)) >> 24, exact for 16-bit x
	localparam logic [17:0] RECIP_100   = 18'd167773;
	localparam int          RECIP_SHIFT = 24;

	typedef struct packed {
		logic [15:0] signal_timeout;
		logic [15:0] link_lost;
		logic [13:0] idle_floor;
	} csd_cfg_t;

	typedef struct packed {
		logic [MSG_N-1:0] hit;
		logic [13:0]      engine_speed;
		logic [2:0]       drive_mode;
		logic             engine_fault;
		logic             brake;
		logic             ready;
		logic             gps;
		logic [2:0]       gear;
		logic [6:0]       power;
		logic [7:0]       battery;
		logic             tcs;
		logic             abs_lamp;
		logic [7:0]       speed;
	} csd_dec_t;

	// packed MSB first, so engine_speed lands in the lowest bits
	typedef struct packed {
		logic        link_ok;
		logic        abs_lamp;
		logic        tcs_warning;
		logic [7:0]  battery_level;
		logic [6:0]  power_percent;
		logic [2:0]  gear;
		logic        gps_lamp;
		logic        ready_lamp;
		logic        brake_lamp;
		logic        engine_fault_lamp;
		logic [2:0]  drive_mode;
		logic [13:0] engine_speed;
	} csd_result_t;

endpackage

### rtl/csd_frame_dec.sv
// ----------------------------------------------------------------------------
// CAN frame field decoder
// Picks the message slot and extracts scaled signal values from one frame.
// ----------------------------------------------------------------------------
module csd_frame_dec (
	input  logic [10:0]       can_id,
	input  logic [3:0]        frame_length,
	input  logic [63:0]       payload,
	input  logic              self_check_started,
	input  logic [13:0]       idle_floor,
	output csd_pkg::csd_dec_t dec
);
	import csd_pkg::*;

	logic [7:0]  b0, b2, b3, b5, b6, b7;
	logic [15:0] raw23, raw56, raw_div;
	logic [33:0] prod;
	logic [9:0]  quot;
	logic [13:0] eng_q4;
	logic        gate;
	logic [MSG_N-1:0] hit;

	assign b0 = payload[7:0];
	assign b2 = payload[23:16];
	assign b3 = payload[31:24];
	assign b5 = payload[47:40];
	assign b6 = payload[55:48];
	assign b7 = payload[63:56];

	assign raw23 = ({b2, b3} == RAW_NONE) ? 16'd0 : {b2, b3};
	assign raw56 = ({b5, b6} == RAW_NONE) ? 16'd0 : {b5, b6};

	// length 8 and above all have bit 3 set
	assign gate = self_check_started & frame_length[3];

	always_comb begin
		hit = '0;
		if (gate) begin
			case (can_id)
				ID_ENG:   hit[MSG_ENG]   = 1'b1;
				ID_MODE:  hit[MSG_MODE]  = 1'b1;
				ID_BODY:  hit[MSG_BODY]  = 1'b1;
				ID_TCS:   hit[MSG_TCS]   = 1'b1;
				ID_SPEED: hit[MSG_SPEED] = 1'b1;
				ID_ABS:   hit[MSG_ABS]   = 1'b1;
				default:  hit = '0;
			endcase
		end
	end

	assign dec.hit = hit;

	// one divide-by-100 serves both power and vehicle speed
	assign raw_div = (can_id == ID_BODY) ? raw56 : raw23;
	assign prod    = {18'd0, raw_div} * {16'd0, RECIP_100};
	assign quot    = prod[RECIP_SHIFT +: 10];

	assign eng_q4 = raw23[15:2];
	assign dec.engine_speed = (eng_q4 != 14'd0 && eng_q4 <= idle_floor) ? idle_floor : eng_q4;

	assign dec.drive_mode   = b0[4:2];
	assign dec.engine_fault = b0[1];
	assign dec.brake        = b0[0];
	assign dec.ready        = b0[1];
	assign dec.gps          = b0[2];
	assign dec.gear         = b2[2:0];
	assign dec.power        = (quot > {3'd0, POWER_MAX}) ? POWER_MAX : quot[6:0];
	assign dec.battery      = (b7 == BATT_NONE) ? 8'd0 : b7;
	assign dec.tcs          = b3[2];
	assign dec.abs_lamp     = b5[0];
	assign dec.speed        = (quot > {2'd0, SPEED_MAX}) ? SPEED_MAX : quot[7:0];

endmodule

### rtl/csd_sig_bank.sv
// ----------------------------------------------------------------------------
// CAN signal bank
// Holds decoded signals and message ages; applies ageing and timeouts.
// ----------------------------------------------------------------------------
module csd_sig_bank #(
	parameter int AGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic                 func,
	input  csd_pkg::csd_dec_t    dec,
	input  csd_pkg::csd_cfg_t    cfg,
	output csd_pkg::csd_result_t res
);
	import csd_pkg::*;

	localparam int CW = (AGE_BITS > 16) ? AGE_BITS : 16;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	logic [AGE_BITS-1:0] age_q [MSG_N];
	logic [AGE_BITS-1:0] age_n [MSG_N];
	logic [AGE_BITS-1:0] link_age_q, link_age_n;
	logic [13:0] eng_q, eng_n;
	logic [2:0]  mode_q, mode_n, gear_q, gear_n;
	logic [6:0]  power_q, power_n;
	logic [7:0]  batt_q, batt_n, speed_q, speed_n;
	logic        fault_q, fault_n, brake_q, brake_n, ready_q, ready_n;
	logic        gps_q, gps_n, tcs_q, tcs_n, abs_q, abs_n;
	logic [MSG_N-1:0] tmo;

	always_comb begin
		eng_n   = eng_q;
		mode_n  = mode_q;
		gear_n  = gear_q;
		power_n = power_q;
		batt_n  = batt_q;
		speed_n = speed_q;
		fault_n = fault_q;
		brake_n = brake_q;
		ready_n = ready_q;
		gps_n   = gps_q;
		tcs_n   = tcs_q;
		abs_n   = abs_q;
		tmo     = '0;
		for (int i = 0; i < MSG_N; i++) begin
			age_n[i] = age_q[i];
		end
		if (func == FUNC_TICK) begin
			link_age_n = (link_age_q == AGE_MAX) ? AGE_MAX : link_age_q + 1'b1;
			for (int i = 0; i < MSG_N; i++) begin
				age_n[i] = (age_q[i] == AGE_MAX) ? AGE_MAX : age_q[i] + 1'b1;
				tmo[i]   = CW'(age_n[i]) > CW'(cfg.signal_timeout);
			end
			if (tmo[MSG_ENG]) begin
				eng_n = '0;
			end
			if (tmo[MSG_MODE]) begin
				mode_n  = '0;
				fault_n = 1'b0;
			end
			if (tmo[MSG_BODY]) begin
				gear_n  = '0;
				brake_n = 1'b0;
				ready_n = 1'b0;
				gps_n   = 1'b0;
				power_n = '0;
				batt_n  = '0;
			end
			if (tmo[MSG_TCS]) begin
				tcs_n = 1'b0;
			end
			if (tmo[MSG_SPEED]) begin
				speed_n = '0;
			end
			if (tmo[MSG_ABS]) begin
				abs_n = 1'b1;
			end
		end else begin
			link_age_n = '0;
			for (int i = 0; i < MSG_N; i++) begin
				if (dec.hit[i]) begin
					age_n[i] = '0;
				end
			end
			if (dec.hit[MSG_ENG]) begin
				eng_n = dec.engine_speed;
			end
			if (dec.hit[MSG_MODE]) begin
				mode_n  = dec.drive_mode;
				fault_n = dec.engine_fault;
			end
			if (dec.hit[MSG_BODY]) begin
				gear_n  = dec.gear;
				brake_n = dec.brake;
				ready_n = dec.ready;
				gps_n   = dec.gps;
				power_n = dec.power;
				batt_n  = dec.battery;
			end
			if (dec.hit[MSG_TCS]) begin
				tcs_n = dec.tcs;
			end
			if (dec.hit[MSG_SPEED]) begin
				speed_n = dec.speed;
			end
			if (dec.hit[MSG_ABS]) begin
				abs_n = dec.abs_lamp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MSG_N; i++) begin
				age_q[i] <= '0;
			end
			link_age_q <= '0;
			eng_q      <= '0;
			mode_q     <= '0;
			gear_q     <= '0;
			power_q    <= '0;
			batt_q     <= '0;
			speed_q    <= '0;
			fault_q    <= 1'b0;
			brake_q    <= 1'b0;
			ready_q    <= 1'b0;
			gps_q      <= 1'b0;
			tcs_q      <= 1'b0;
			abs_q      <= 1'b1;
		end else if (upd) begin
			for (int i = 0; i < MSG_N; i++) begin
				age_q[i] <= age_n[i];
			end
			link_age_q <= link_age_n;
			eng_q      <= eng_n;
			mode_q     <= mode_n;
			gear_q     <= gear_n;
			power_q    <= power_n;
			batt_q     <= batt_n;
			speed_q    <= speed_n;
			fault_q    <= fault_n;
			brake_q    <= brake_n;
			ready_q    <= ready_n;
			gps_q      <= gps_n;
			tcs_q      <= tcs_n;
			abs_q      <= abs_n;
		end
	end

	assign res.engine_speed      = eng_n;
	assign res.drive_mode        = mode_n;
	assign res.engine_fault_lamp = fault_n;
	assign res.brake_lamp        = brake_n;
	assign res.ready_lamp        = ready_n;
	assign res.gps_lamp          = gps_n;
	assign res.gear              = gear_n;
	assign res.power_percent     = power_n;
	assign res.battery_level     = batt_n;
	assign res.tcs_warning       = tcs_n;
	assign res.abs_lamp          = abs_n;
	assign res.link_ok           = CW'(link_age_n) <= CW'(cfg.link_lost);

endmodule

### rtl/can_signal_decoder_with_timeouts_top.sv
// ----------------------------------------------------------------------------
// CAN signal decoder with timeouts - top level
// Decodes received frames and millisecond ticks into a vehicle signal bank.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | contents
//  --------+-----+----------------------+-----------------------------------
//  s_*     | in  | s_tvalid / s_tready  | frame or tick item (tuser = func)
//  m_*     | out | m_tvalid / m_tready  | signal bank snapshot, one per item
//  cfg_*   | in  | cfg_we, no wait      | timeout, link limit, idle floor
//
// One item a cycle sustained while the output is not stalled; an accepted
// item passes the input register, then the decode/update into the result reg.
// The update path is one 16x18 multiply for the /100 scaling plus compares.
// Reset: async, active low; signals clear, ABS lamp lit, config to defaults.
// A stalled output holds the result; the input register still takes one
// more item, and s_tready drops only when both stages are full.
// ----------------------------------------------------------------------------
`include "can_signal_decoder_with_timeouts_top_macros.svh"

module can_signal_decoder_with_timeouts_top #(
	parameter int AGE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [10:0] can_id, [14:11] frame_length, [78:15] payload,
	// [79] self_check_started
	input  logic [79:0] s_tdata,
	// [0] func (0 frame, 1 tick)
	input  logic        s_tuser,
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [13:0] engine_speed, [16:14] drive_mode, [17] engine_fault_lamp,
	// [18] brake_lamp, [19] ready_lamp, [20] gps_lamp, [23:21] gear,
	// [30:24] power_percent, [38:31] battery_level, [39] tcs_warning,
	// [40] abs_lamp, [41] link_ok, [47:42] zero
	output logic [47:0] m_tdata,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	import csd_pkg::*;

	// input register stage
	logic        valid_s1;
	logic [79:0] item_s1;
	logic        func_s1;

	// result register
	logic        out_valid_q;
	csd_result_t res_q;

	csd_cfg_t    cfg_q;
	csd_dec_t    dec;
	csd_result_t res;
	logic        adv;

	// item in s1 moves into the result register when it is free or draining
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_tdata;
			func_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signal_timeout <= TIMEOUT_RST;
			cfg_q.link_lost      <= LINK_RST;
			cfg_q.idle_floor     <= FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_TIMEOUT: cfg_q.signal_timeout <= cfg_wdata;
				CFG_LINK:    cfg_q.link_lost      <= cfg_wdata;
				CFG_FLOOR:   cfg_q.idle_floor     <= cfg_wdata[13:0];
				default:     ; // unused index, write dropped
			endcase
		end
	end

	csd_frame_dec u_dec (
		.can_id             (item_s1[10:0]),
		.frame_length       (item_s1[14:11]),
		.payload            (item_s1[78:15]),
		.self_check_started (item_s1[79]),
		.idle_floor         (cfg_q.idle_floor),
		.dec                (dec)
	);

	csd_sig_bank #(
		.AGE_BITS (AGE_BITS)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.func   (func_s1),
		.dec    (dec),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

	// ---- assertions ----
	`CSD_ASSERT_IMP(a_full_stall, clk, arst_n, valid_s1 && out_valid_q && !m_tready, !s_tready)
	`CSD_ASSERT_NXT(a_adv_valid, clk, arst_n, adv, out_valid_q)
	`CSD_ASSERT_NXT(a_frame_link, clk, arst_n, adv && func_s1 == FUNC_FRAME, res_q.link_ok)
	`CSD_ASSERT_IMP(a_hit_onehot, clk, arst_n, 1'b1, $onehot0(dec.hit))

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// CAN signal decoder with timeouts - testbench
// Streams frames and millisecond ticks into the decoder under random source
// and sink stalls. Every accepted item is run through a local model of the
// signal bank, and each output snapshot is checked field by field against it.
// Covers decode of every message, the idle floor, the clamps, raw all-ones,
// gating, timeouts down to zero, link loss and a timeout at its top value.
// ----------------------------------------------------------------------------
module testbench;
	import csd_pkg::*;

	// ages saturate at all ones for the default AGE_BITS of the block
	localparam bit [15:0] AGE_MAX = 16'hFFFF;
	// register index with no register behind it; writes must be ignored
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int GAP_PCT = 33;

	typedef struct packed {
		bit        func;
		bit [10:0] can_id;
		bit [3:0]  frame_len;
		bit [63:0] payload;
		bit        started;
	} can_item_t;

	// Local model of the signal bank; one expected snapshot per accepted item.
	class signal_bank_scoreboard;
		bit [15:0]   timeout_ms;
		bit [15:0]   link_lost_ms;
		bit [13:0]   idle_floor;
		bit [15:0]   msg_age [MSG_N];
		bit [15:0]   link_age;
		bit [13:0]   eng_speed;
		bit [2:0]    mode;
		bit [2:0]    gear;
		bit [6:0]    power;
		bit [7:0]    battery;
		bit [7:0]    speed;
		bit          lamp_fault, lamp_brake, lamp_ready, lamp_gps, lamp_tcs, lamp_abs;
		csd_result_t expected_banks [$];
		int          errors;

		function new();
			timeout_ms   = TIMEOUT_RST;
			link_lost_ms = LINK_RST;
			idle_floor   = FLOOR_RST;
			foreach (msg_age[i])
				msg_age[i] = '0;
			link_age   = '0;
			eng_speed  = '0;
			mode       = '0;
			gear       = '0;
			power      = '0;
			battery    = '0;
			speed      = '0;
			lamp_fault = 1'b0;
			lamp_brake = 1'b0;
			lamp_ready = 1'b0;
			lamp_gps   = 1'b0;
			lamp_tcs   = 1'b0;
			lamp_abs   = 1'b1;
			errors     = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				CFG_TIMEOUT: timeout_ms = data;
				CFG_LINK:    link_lost_ms = data;
				CFG_FLOOR:   idle_floor = data[13:0];
				default:     ;
			endcase
		endfunction

		// 16-bit value from bytes hi and hi+1, all ones reads as nothing
		function bit [15:0] raw16(bit [63:0] p, int hi);
			bit [15:0] r;
			r = {p[8*hi +: 8], p[8*(hi+1) +: 8]};
			return (r == RAW_NONE) ? 16'd0 : r;
		endfunction

		function void note_item(can_item_t it);
			int unsigned v;
			int          i;
			csd_result_t bank;
			if (it.func == FUNC_TICK) begin
				for (i = 0; i < MSG_N; i++)
					if (msg_age[i] != AGE_MAX)
						msg_age[i]++;
				if (link_age != AGE_MAX)
					link_age++;
				// forcing happens after aging, and only on ticks
				if (msg_age[MSG_ENG] > timeout_ms)
					eng_speed = '0;
				if (msg_age[MSG_MODE] > timeout_ms) begin
					mode       = '0;
					lamp_fault = 1'b0;
				end
				if (msg_age[MSG_BODY] > timeout_ms) begin
					gear       = '0;
					lamp_brake = 1'b0;
					lamp_ready = 1'b0;
					lamp_gps   = 1'b0;
					power      = '0;
					battery    = '0;
				end
				if (msg_age[MSG_TCS] > timeout_ms)
					lamp_tcs = 1'b0;
				if (msg_age[MSG_SPEED] > timeout_ms)
					speed = '0;
				if (msg_age[MSG_ABS] > timeout_ms)
					lamp_abs = 1'b1;
			end else begin
				// any frame at all refreshes the link
				link_age = '0;
				if (it.started && it.frame_len >= 4'd8) begin
					case (it.can_id)
						ID_ENG: begin
							v = 32'(raw16(it.payload, 2) >> 2);
							if (v != 0 && v <= idle_floor)
								v = 32'(idle_floor);
							eng_speed        = v[13:0];
							msg_age[MSG_ENG] = '0;
						end
						ID_MODE: begin
							lamp_fault        = it.payload[1];
							mode              = it.payload[4:2];
							msg_age[MSG_MODE] = '0;
						end
						ID_BODY: begin
							lamp_brake = it.payload[0];
							lamp_ready = it.payload[1];
							lamp_gps   = it.payload[2];
							gear       = it.payload[18:16];
							v          = raw16(it.payload, 5) / 100;
							power      = (v > POWER_MAX) ? POWER_MAX : v[6:0];
							battery    = (it.payload[63:56] == BATT_NONE) ? 8'd0 :
								it.payload[63:56];
							msg_age[MSG_BODY] = '0;
						end
						ID_TCS: begin
							lamp_tcs         = it.payload[26];
							msg_age[MSG_TCS] = '0;
						end
						ID_SPEED: begin
							v                  = raw16(it.payload, 2) / 100;
							speed              = (v > SPEED_MAX) ? SPEED_MAX : v[7:0];
							msg_age[MSG_SPEED] = '0;
						end
						ID_ABS: begin
							lamp_abs         = it.payload[40];
							msg_age[MSG_ABS] = '0;
						end
						default: ;
					endcase
				end
			end
			bank.engine_speed      = eng_speed;
			bank.drive_mode        = mode;
			bank.engine_fault_lamp = lamp_fault;
			bank.brake_lamp        = lamp_brake;
			bank.ready_lamp        = lamp_ready;
			bank.gps_lamp          = lamp_gps;
			bank.gear              = gear;
			bank.power_percent     = power;
			bank.battery_level     = battery;
			bank.tcs_warning       = lamp_tcs;
			bank.abs_lamp          = lamp_abs;
			bank.link_ok           = (link_age <= link_lost_ms);
			expected_banks.push_back(bank);
		endfunction

		task report(string msg);
			errors++;
			// keep the log short if things go badly wrong
			if (errors <= 100)
				$display("item check failed: %s", msg);
		endtask

		task compare(string name, logic [15:0] got, bit [15:0] want);
			if (got !== want)
				report($sformatf("%s got %0d, expected %0d", name, got, want));
		endtask

		task check_result(logic [47:0] data);
			csd_result_t got, want;
			if (expected_banks.size() == 0) begin
				report("snapshot with no item waiting for it");
				return;
			end
			want = expected_banks.pop_front();
			got  = data[41:0];
			compare("engine_speed", 16'(got.engine_speed), 16'(want.engine_speed));
			compare("drive_mode", 16'(got.drive_mode), 16'(want.drive_mode));
			compare("engine_fault_lamp", 16'(got.engine_fault_lamp),
				16'(want.engine_fault_lamp));
			compare("brake_lamp", 16'(got.brake_lamp), 16'(want.brake_lamp));
			compare("ready_lamp", 16'(got.ready_lamp), 16'(want.ready_lamp));
			compare("gps_lamp", 16'(got.gps_lamp), 16'(want.gps_lamp));
			compare("gear", 16'(got.gear), 16'(want.gear));
			compare("power_percent", 16'(got.power_percent), 16'(want.power_percent));
			compare("battery_level", 16'(got.battery_level), 16'(want.battery_level));
			compare("tcs_warning", 16'(got.tcs_warning), 16'(want.tcs_warning));
			compare("abs_lamp", 16'(got.abs_lamp), 16'(want.abs_lamp));
			compare("link_ok", 16'(got.link_ok), 16'(want.link_ok));
			compare("padding", 16'(data[47:42]), 16'd0);
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [79:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tready  = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_idx   = '0;
	logic [15:0] cfg_wdata = '0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [47:0] m_tdata;

	// both sides stop stalling while this is set
	bit calm = 1'b0;

	signal_bank_scoreboard sb;

	can_signal_decoder_with_timeouts_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sink: random back-pressure, changed on the falling edge
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
	end

	// output snapshots are sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// One item onto the input stream; random gaps before it. Valid is left
	// high after acceptance, the next call or a drain decides what follows.
	task send_item(can_item_t it);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {it.started, it.payload, it.frame_len, it.can_id};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(it);
	endtask

	// stop sending, let every snapshot come back, then allow the pipe to settle
	task wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_banks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	function can_item_t frame(bit [10:0] id, bit [63:0] p, bit [3:0] len = 4'd8,
			bit started = 1'b1);
		return '{func: FUNC_FRAME, can_id: id, frame_len: len, payload: p,
			started: started};
	endfunction

	// tick with junk in every field the block should ignore
	function can_item_t tick_item();
		return '{func: FUNC_TICK, can_id: 11'($urandom), frame_len: 4'($urandom),
			payload: {$urandom, $urandom}, started: 1'($urandom)};
	endfunction

	// random payload with a 16-bit raw value at bytes k, k+1
	function bit [63:0] with_raw(int k, bit [15:0] raw);
		bit [63:0] p;
		p = {$urandom, $urandom};
		p[8*k +: 8]     = raw[15:8];
		p[8*k + 8 +: 8] = raw[7:0];
		return p;
	endfunction

	// Mostly well-formed frames for the decoded IDs with random content,
	// raw values pushed towards the floor and clamp edges now and then;
	// the rest is foreign IDs, short frames and frames before self-check.
	task make_random(int tick_pct, output can_item_t it);
		bit [15:0] raw;
		it = tick_item();
		if ($urandom_range(0, 99) < tick_pct)
			return;
		it.func = FUNC_FRAME;
		if ($urandom_range(0, 99) < 80) begin
			case ($urandom_range(0, 5))
				0:       it.can_id = ID_ENG;
				1:       it.can_id = ID_MODE;
				2:       it.can_id = ID_BODY;
				3:       it.can_id = ID_TCS;
				4:       it.can_id = ID_SPEED;
				default: it.can_id = ID_ABS;
			endcase
			it.started   = 1'b1;
			it.frame_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
		end
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 5))
				0:       raw = RAW_NONE;
				1:       raw = 16'($urandom_range(0, 15));
				2:       raw = 16'({sb.idle_floor, 2'b00} + $urandom_range(0, 7));
				3:       raw = 16'($urandom_range(9900, 10200));
				4:       raw = 16'($urandom_range(19800, 20100));
				default: raw = 16'hFFFE;
			endcase
			it.payload[23:16] = raw[15:8];
			it.payload[31:24] = raw[7:0];
			it.payload[47:40] = raw[15:8];
			it.payload[55:48] = raw[7:0];
		end
		if ($urandom_range(0, 9) == 0)
			it.payload[63:56] = BATT_NONE;
	endtask

	task run_phase(logic [15:0] timeout_ms, logic [15:0] link_ms, logic [15:0] floor_wd,
			int n, int tick_pct);
		can_item_t it;
		wait_drain();
		write_reg(CFG_TIMEOUT, timeout_ms);
		write_reg(CFG_LINK, link_ms);
		write_reg(CFG_FLOOR, floor_wd);
		repeat (n) begin
			make_random(tick_pct, it);
			send_item(it);
		end
	endtask

	initial begin
		bit [63:0] p;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, at reset settings
		send_item(tick_item());
		send_item(frame(ID_ENG, with_raw(2, 16'd4), 4'd8, 1'b0));	// before self-check
		send_item(frame(ID_ENG, with_raw(2, 16'd4), 4'd7));		// short frame
		send_item(frame(ID_ENG, with_raw(2, 16'd4)));			// lifted to the floor
		send_item(frame(ID_ENG, with_raw(2, 16'd3)));			// zero stays zero
		send_item(frame(ID_ENG, with_raw(2, RAW_NONE)));
		send_item(frame(ID_ENG, with_raw(2, 16'hFFFE)));		// top of range
		send_item(frame(ID_ENG, with_raw(2, 16'd6804)));		// just over the floor
		send_item(frame(ID_MODE, 64'hFF, 4'd15));			// length above 8
		send_item(frame(ID_MODE, 64'h0));
		p = with_raw(5, 16'd10100);
		p[7:0]   = 8'h07;
		p[23:16] = 8'h07;
		p[63:56] = BATT_NONE;
		send_item(frame(ID_BODY, p));					// power clamp, no battery
		p = with_raw(5, RAW_NONE);
		p[7:0]   = 8'h00;
		p[63:56] = 8'd254;
		send_item(frame(ID_BODY, p));
		send_item(frame(ID_BODY, with_raw(5, 16'd9999)));
		send_item(frame(ID_TCS, 64'h0000_0000_0400_0000));
		send_item(frame(ID_SPEED, with_raw(2, 16'd19900)));
		send_item(frame(ID_SPEED, with_raw(2, 16'd20000)));		// speed clamp
		send_item(frame(ID_SPEED, with_raw(2, RAW_NONE)));
		send_item(frame(ID_ABS, 64'h0));
		send_item(frame(ID_ABS, 64'h0000_0100_0000_0000));
		send_item(frame(11'h113, {$urandom, $urandom}));		// foreign ID
		send_item(frame(11'h7FF, '1, 4'd15));
		send_item(frame(11'h000, '0, 4'd0, 1'b0));
		send_item(tick_item());

		// random phases across the register range
		run_phase(16'd0, 16'd0, 16'd0, 60, 40);				// zero timeout: forced on next tick
		run_phase(16'd1, 16'd1, 16'd16383, 80, 40);
		calm = 1'b1;
		run_phase(16'd5, 16'd8, 16'($urandom_range(0, 16383)), 200, 45);
		calm = 1'b0;
		run_phase(16'd20, 16'd40, 16'($urandom_range(0, 16383)), 200, 50);
		run_phase(16'($urandom_range(2, 60)), 16'($urandom_range(2, 100)),
			16'($urandom_range(0, 16383)), 200, 55);

		// Timeout at all ones: a few ticks leave every signal in place.
		// Floor written with junk in the unused top bits.
		wait_drain();
		write_reg(CFG_TIMEOUT, AGE_MAX);
		write_reg(CFG_LINK, 16'd65534);
		write_reg(CFG_FLOOR, 16'hC6A4);
		send_item(frame(ID_ENG, with_raw(2, 16'd20000)));
		send_item(frame(ID_MODE, {$urandom, $urandom}));
		send_item(frame(ID_BODY, {$urandom, $urandom}));
		send_item(frame(ID_TCS, {$urandom, $urandom}));
		send_item(frame(ID_SPEED, {$urandom, $urandom}));
		send_item(frame(ID_ABS, 64'h0));
		repeat (20) send_item(tick_item());
		wait_drain();
		write_reg(CFG_SPARE, 16'($urandom));
		run_phase(16'd65534, 16'd1, 16'd1700, 60, 40);

		wait_drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_banks.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
